// ----- hw/rtl/rgb_conv2d_mirror_edges_core_assert.svh -----
// Assertion macros shared by the convolution core.
`ifndef RGB_CONV2D_MIRROR_EDGES_CORE_ASSERT_SVH
`define RGB_CONV2D_MIRROR_EDGES_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RCM_ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define RCM_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define RCM_ASSERT_IMPL(label, clk, rst, prop)
`define RCM_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ----- hw/rtl/rcm_pkg.sv -----
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared commands and register indexes of the RGB convolution core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rcm_pkg;
  localparam logic [1:0] CMD_COEF  = 2'd0;
  localparam logic [1:0] CMD_PIXEL = 2'd1;
  localparam logic [1:0] CMD_DRAIN = 2'd2;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MASK_HEIGHT  = 2'd2;
  localparam logic [1:0] REG_MASK_WIDTH   = 2'd3;

  localparam int CFG_DATA_W = 16;
endpackage

// ----- hw/rtl/rgb_conv2d_mirror_edges_core.sv -----
// ----------------------------------------------------------------------------
// rgb_conv2d_mirror_edges_core
// RGB 2-D convolution with mirrored edges over a streamed raster frame.
// ----------------------------------------------------------------------------
// Items enter on a valid/ready input channel: coefficient writes, pixels in
// raster order, and drain steps. Each accepted beat causes at most one output
// beat on the valid/ready output channel, in raster order.
// A beat that releases an output with an odd mask walks the window with one
// shared three-channel multiply-accumulate, one tap per cycle; an even mask
// skips the walk and gives a zero result. The line store and kernel memory
// each give one read per cycle.
// After reset the block first clears the kernel memory, one entry per cycle,
// before taking input. The user must make configuration writes only while
// idle; the block itself does not enforce this. When the receiver stalls, the
// result waits in the output register and no new item is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rgb_conv2d_mirror_edges_core_assert.svh"
module rgb_conv2d_mirror_edges_core
  import rcm_pkg::*;
#(
  parameter int MAX_MASK = 25,
  parameter int MAX_WIDTH = 1024,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            cmd,
  input  logic [4:0]            coef_row,
  input  logic [4:0]            coef_col,
  input  logic signed [17:0]    coef_value,
  input  logic [7:0]            pixel_red,
  input  logic [7:0]            pixel_green,
  input  logic [7:0]            pixel_blue,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [15:0]           out_row,
  output logic [9:0]            out_col,
  output logic                  frame_last
);
  localparam int LS_ROWS = MAX_MASK + 1;
  localparam int KDEPTH = MAX_MASK * MAX_MASK;
  localparam int KAW = $clog2(KDEPTH);
  localparam int COLW = $clog2(MAX_WIDTH);
  localparam int SLOTW = $clog2(LS_ROWS);
  localparam int LSAW = $clog2(LS_ROWS * MAX_WIDTH);
  localparam int MW = 6;
  localparam int ACCW = 8 + 18 + 11;
  localparam int WW = COLW + 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_MAC, S_FLUSH, S_ROUND, S_OUT
  } state_t;
  state_t state;

  logic [WW-1:0] frame_width;
  logic [15:0]   frame_height;
  logic [4:0]    mask_height, mask_width;

  logic [17:0] kmem [KDEPTH];
  logic [23:0] lmem [LS_ROWS * MAX_WIDTH];
  logic [17:0] krd;
  logic [23:0] lrd;

  logic [15:0]     in_row;
  logic [COLW:0]   in_col;
  logic [15:0]     em_row;
  logic [COLW:0]   em_col;
  logic            tail;
  logic [SLOTW-1:0] in_slot;
  logic [KAW-1:0]  clr_addr;

  // effective sizes
  logic [WW-1:0] ew;
  logic [15:0]   eh;
  logic [MW-1:0] mh, mw, rh, rw;
  always_comb begin
    if (frame_width == '0) ew = WW'(1);
    else if (frame_width > WW'(MAX_WIDTH)) ew = WW'(MAX_WIDTH);
    else ew = frame_width;
    eh = (frame_height == '0) ? 16'd1 : frame_height;
    mh = (MW'(mask_height) > MW'(MAX_MASK)) ? MW'(MAX_MASK) : MW'(mask_height);
    mw = (MW'(mask_width) > MW'(MAX_MASK)) ? MW'(MAX_MASK) : MW'(mask_width);
    rh = (mh == '0) ? '0 : MW'((mh - MW'(1)) >> 1);
    rw = (mw == '0) ? '0 : MW'((mw - MW'(1)) >> 1);
  end

  // window readiness
  logic ready_now;
  logic [16:0] nr;
  logic [16:0] nc;
  always_comb begin
    nr = 17'(em_row) + 17'(rh);
    nc = 17'(em_col) + 17'(rw);
    if (nr > 17'(eh) - 17'd1) nr = 17'(eh) - 17'd1;
    if (nc > 17'(ew) - 17'd1) nc = 17'(ew) - 17'd1;
    ready_now = tail || (17'(in_row) > nr) ||
                ((17'(in_row) == nr) && (17'(in_col) > nc));
  end

  // tap walker
  logic [MW-1:0] tm, tn;
  logic signed [18:0] ii, jj, ir, jr;
  logic [SLOTW-1:0] tap_slot;
  always_comb begin
    ir = 19'(em_row) - 19'(rh) + 19'(tm);
    jr = 19'(em_col) - 19'(rw) + 19'(tn);
    ii = (ir < 0) ? -ir : ir;
    if (ii >= 19'(eh)) ii = 19'sd2 * 19'(eh) - 19'sd2 - ii;
    if (ii < 0) ii = '0;
    if (ii > 19'(eh) - 19'sd1) ii = 19'(eh) - 19'sd1;
    jj = (jr < 0) ? -jr : jr;
    if (jj >= 19'(ew)) jj = 19'sd2 * 19'(ew) - 19'sd2 - jj;
    if (jj < 0) jj = '0;
    if (jj > 19'(ew) - 19'sd1) jj = 19'(ew) - 19'sd1;
    tap_slot = SLOTW'(32'(ii[15:0]) % LS_ROWS);
  end

  logic             mac_v;
  logic             last_tap;
  logic signed [ACCW-1:0] acc_r, acc_g, acc_b;
  logic             odd_mask;
  assign odd_mask = mh[0] && mw[0];

  function automatic logic [7:0] sat_ch(input logic signed [ACCW-1:0] a);
    logic signed [ACCW-1:0] s;
    begin
      s = a >>> COEF_FRAC_BITS;
      if (a < 0) sat_ch = 8'd0;
      else if (s > 255) sat_ch = 8'd255;
      else sat_ch = s[7:0];
    end
  endfunction

  logic in_fire;
  assign in_ready = (state == S_IDLE);
  assign in_fire = in_valid && in_ready;

  logic k_we;
  logic [KAW-1:0] k_wa;
  logic [17:0] k_wd;
  logic [KAW-1:0] k_ra;
  always_comb begin
    k_we = 1'b0;
    k_wa = clr_addr;
    k_wd = '0;
    if (state == S_CLEAR) begin
      k_we = 1'b1;
    end else if (in_fire && cmd == CMD_COEF && coef_row < 5'(MAX_MASK) &&
                 coef_col < 5'(MAX_MASK)) begin
      k_we = 1'b1;
      k_wa = KAW'(32'(coef_row) * MAX_MASK + 32'(coef_col));
      k_wd = coef_value;
    end
    k_ra = KAW'(32'(tm) * MAX_MASK + 32'(tn));
  end

  always_ff @(posedge clk) begin
    if (k_we) kmem[k_wa] <= k_wd;
    krd <= kmem[k_ra];
    lrd <= lmem[LSAW'(32'(tap_slot) * MAX_WIDTH + 32'(jj[COLW-1:0]))];
    if (in_fire && cmd == CMD_PIXEL && !tail && in_col < (COLW+1)'(MAX_WIDTH))
      lmem[LSAW'(32'(in_slot) * MAX_WIDTH + 32'(in_col[COLW-1:0]))] <=
        {pixel_blue, pixel_green, pixel_red};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      frame_width <= WW'(1024);
      frame_height <= 16'd1024;
      mask_height <= 5'd25;
      mask_width <= 5'd25;
      in_row <= '0; in_col <= '0; em_row <= '0; em_col <= '0;
      tail <= 1'b0; in_slot <= '0;
      out_valid <= 1'b0; mac_v <= 1'b0;
      tm <= '0; tn <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_width <= cfg_data[WW-1:0];
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          REG_MASK_HEIGHT:  mask_height <= cfg_data[4:0];
          REG_MASK_WIDTH:   mask_width <= cfg_data[4:0];
          default: ;
        endcase
      end
      // The input column counter, if past a new width, wraps to zero while idle.
      if (in_col >= (COLW+1)'(ew) && state == S_IDLE && !in_fire) in_col <= '0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + KAW'(1);
          if (32'(clr_addr) == KDEPTH - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire) begin
            if (cmd == CMD_PIXEL && !tail) begin
              if (in_col + 1'b1 >= (COLW+1)'(ew)) begin
                in_col <= '0;
                if (in_row + 16'd1 >= eh) begin
                  in_row <= '0; in_slot <= '0; tail <= 1'b1;
                end else begin
                  in_row <= in_row + 16'd1;
                  in_slot <= (32'(in_slot) == LS_ROWS - 1) ? '0 : in_slot + SLOTW'(1);
                end
              end else begin
                in_col <= in_col + 1'b1;
              end
              state <= S_CHECK;
            end else if (cmd == CMD_PIXEL || cmd == CMD_DRAIN) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          tm <= '0; tn <= '0;
          acc_r <= '0; acc_g <= '0; acc_b <= '0;
          if (!ready_now) state <= S_IDLE;
          else if (!odd_mask) state <= S_ROUND;
          else state <= S_MAC;
        end
        S_MAC: begin
          mac_v <= 1'b1;
          last_tap <= (tm == mh - MW'(1)) && (tn == mw - MW'(1));
          if (tn == mw - MW'(1)) begin
            tn <= '0; tm <= tm + MW'(1);
          end else begin
            tn <= tn + MW'(1);
          end
          if (mac_v) begin
            acc_r <= acc_r + ACCW'($signed({1'b0, lrd[7:0]}) * $signed(krd));
            acc_g <= acc_g + ACCW'($signed({1'b0, lrd[15:8]}) * $signed(krd));
            acc_b <= acc_b + ACCW'($signed({1'b0, lrd[23:16]}) * $signed(krd));
          end
          if ((tm == mh - MW'(1)) && (tn == mw - MW'(1))) state <= S_FLUSH;
        end
        S_FLUSH: begin
          mac_v <= 1'b0;
          acc_r <= acc_r + ACCW'($signed({1'b0, lrd[7:0]}) * $signed(krd));
          acc_g <= acc_g + ACCW'($signed({1'b0, lrd[15:8]}) * $signed(krd));
          acc_b <= acc_b + ACCW'($signed({1'b0, lrd[23:16]}) * $signed(krd));
          state <= S_ROUND;
        end
        S_ROUND: begin
          out_red <= sat_ch(acc_r);
          out_green <= sat_ch(acc_g);
          out_blue <= sat_ch(acc_b);
          out_row <= em_row;
          out_col <= em_col[9:0];
          out_valid <= 1'b1;
          if (em_row >= eh - 16'd1 && em_col >= (COLW+1)'(ew) - 1'b1) begin
            frame_last <= 1'b1;
            em_row <= '0; em_col <= '0; tail <= 1'b0;
          end else begin
            frame_last <= 1'b0;
            if (em_col + 1'b1 >= (COLW+1)'(ew)) begin
              em_col <= '0; em_row <= em_row + 16'd1;
            end else begin
              em_col <= em_col + 1'b1;
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RCM_ASSERT_IMPL(a_out_only_in_out, clk, rst, out_valid |-> state == S_OUT)
  `RCM_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_row))
  `RCM_ASSERT_IMPL(a_no_take_busy, clk, rst, in_ready |-> !out_valid)
  `RCM_ASSERT_NEXT(a_check_follows, clk, rst, in_fire && cmd == CMD_DRAIN, state == S_CHECK)
endmodule

// ----- tb/rgb_conv2d_mirror_edges_core_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_conv2d_mirror_edges_core_checker
// Watches the configuration port and both streams of the convolution core,
// predicts every filtered pixel, and compares each output beat with it.
// ----------------------------------------------------------------------------
module rgb_conv2d_mirror_edges_core_checker
  import rcm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            cmd,
  input  logic [4:0]            coef_row,
  input  logic [4:0]            coef_col,
  input  logic signed [17:0]    coef_value,
  input  logic [7:0]            pixel_red,
  input  logic [7:0]            pixel_green,
  input  logic [7:0]            pixel_blue,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            out_red,
  input  logic [7:0]            out_green,
  input  logic [7:0]            out_blue,
  input  logic [15:0]           out_row,
  input  logic [9:0]            out_col,
  input  logic                  frame_last,
  output int                    errors,
  output int                    pixels_pending,
  output int                    frame_outputs_owed
);
  localparam int MASK_MAX = 25;
  localparam int WIDTH_MAX = 1024;
  localparam int FRAC_BITS = 16;
  localparam int STORE_ROWS = MASK_MAX + 1;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] row;
    logic [9:0]  col;
    logic        last;
  } filtered_pixel_t;

  filtered_pixel_t filtered_q[$];
  logic [23:0] line_mem[STORE_ROWS * WIDTH_MAX];
  logic signed [17:0] kernel_mem[MASK_MAX * MASK_MAX];
  int in_row, in_col, emit_row, emit_col;
  bit tail_open;
  int frame_w_reg, frame_h_reg, mask_h_reg, mask_w_reg;
  int mismatches;

  function automatic int width_used();
    return (frame_w_reg < 1) ? 1 : (frame_w_reg > WIDTH_MAX) ? WIDTH_MAX : frame_w_reg;
  endfunction

  function automatic int height_used();
    return (frame_h_reg == 0) ? 1 : frame_h_reg;
  endfunction

  function automatic int mask_used(input int m);
    return (m > MASK_MAX) ? MASK_MAX : m;
  endfunction

  function automatic int mask_radius(input int m);
    return (m == 0) ? 0 : (m - 1) / 2;
  endfunction

  function automatic int reflect(input int idx, input int n);
    int k;
    k = idx;
    if (k < 0) k = -k;
    if (k >= n) k = 2 * n - 2 - k;
    if (k < 0) k = 0;
    if (k > n - 1) k = n - 1;
    return k;
  endfunction

  // Fraction bits are dropped only for non-negative sums, so this truncates toward zero.
  function automatic logic [7:0] clip_channel(input longint acc);
    longint v;
    if (acc < 0) return 8'd0;
    v = acc >>> FRAC_BITS;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic bit window_complete();
    int nr, nc;
    if (tail_open) return 1'b1;
    nr = emit_row + mask_radius(mask_used(mask_h_reg));
    nc = emit_col + mask_radius(mask_used(mask_w_reg));
    if (nr > height_used() - 1) nr = height_used() - 1;
    if (nc > width_used() - 1) nc = width_used() - 1;
    return (in_row > nr) || (in_row == nr && in_col > nc);
  endfunction

  task automatic predict_output();
    int w, h, mh, mw, rh, rw, ii, jj;
    longint acc_r, acc_g, acc_b, k;
    logic [23:0] px;
    filtered_pixel_t res;
    w = width_used();
    h = height_used();
    mh = mask_used(mask_h_reg);
    mw = mask_used(mask_w_reg);
    rh = mask_radius(mh);
    rw = mask_radius(mw);
    acc_r = 0;
    acc_g = 0;
    acc_b = 0;
    if (!window_complete()) return;
    if (mh[0] && mw[0]) begin
      for (int m = 0; m < mh; m++) begin
        ii = reflect(emit_row - rh + m, h);
        for (int n = 0; n < mw; n++) begin
          jj = reflect(emit_col - rw + n, w);
          px = line_mem[(ii % STORE_ROWS) * WIDTH_MAX + jj];
          k = kernel_mem[m * MASK_MAX + n];
          acc_r += longint'(px[7:0]) * k;
          acc_g += longint'(px[15:8]) * k;
          acc_b += longint'(px[23:16]) * k;
        end
      end
    end
    res.red = clip_channel(acc_r);
    res.green = clip_channel(acc_g);
    res.blue = clip_channel(acc_b);
    res.row = emit_row[15:0];
    res.col = emit_col[9:0];
    res.last = (emit_row >= h - 1) && (emit_col >= w - 1);
    filtered_q.push_back(res);
    if (res.last) begin
      emit_row = 0;
      emit_col = 0;
      tail_open = 1'b0;
    end else begin
      emit_col++;
      if (emit_col >= w) begin
        emit_col = 0;
        emit_row++;
      end
    end
  endtask

  task automatic accept_item();
    if (cmd == CMD_COEF) begin
      if (coef_row < MASK_MAX && coef_col < MASK_MAX)
        kernel_mem[coef_row * MASK_MAX + coef_col] = coef_value;
    end else if (cmd == CMD_PIXEL && !tail_open) begin
      if (in_col < WIDTH_MAX)
        line_mem[(in_row % STORE_ROWS) * WIDTH_MAX + in_col] = {pixel_blue, pixel_green, pixel_red};
      in_col++;
      if (in_col >= width_used()) begin
        in_col = 0;
        in_row++;
        if (in_row >= height_used()) begin
          in_row = 0;
          tail_open = 1'b1;
        end
      end
      predict_output();
    end else if (cmd == CMD_PIXEL || cmd == CMD_DRAIN) begin
      predict_output();
    end
  endtask

  task automatic compare_output();
    filtered_pixel_t exp_px;
    if (filtered_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: output beat row %0d col %0d with nothing expected", out_row, out_col);
      return;
    end
    exp_px = filtered_q.pop_front();
    if (out_red !== exp_px.red || out_green !== exp_px.green || out_blue !== exp_px.blue ||
        out_row !== exp_px.row || out_col !== exp_px.col || frame_last !== exp_px.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: expected rgb %0d/%0d/%0d at (%0d,%0d) last %0b, got %0d/%0d/%0d at (%0d,%0d) last %0b",
                 exp_px.red, exp_px.green, exp_px.blue, exp_px.row, exp_px.col, exp_px.last,
                 out_red, out_green, out_blue, out_row, out_col, frame_last);
    end
  endtask

  initial begin
    for (int i = 0; i < STORE_ROWS * WIDTH_MAX; i++) line_mem[i] = '0;
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MASK_MAX * MASK_MAX; i++) kernel_mem[i] = '0;
      in_row = 0;
      in_col = 0;
      emit_row = 0;
      emit_col = 0;
      tail_open = 1'b0;
      frame_w_reg = 1024;
      frame_h_reg = 1024;
      mask_h_reg = 25;
      mask_w_reg = 25;
      filtered_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_w_reg = cfg_data[10:0];
          REG_FRAME_HEIGHT: frame_h_reg = cfg_data[15:0];
          REG_MASK_HEIGHT:  mask_h_reg = cfg_data[4:0];
          REG_MASK_WIDTH:   mask_w_reg = cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) accept_item();
      if (out_valid && out_ready) compare_output();
    end
    errors <= mismatches;
    pixels_pending <= filtered_q.size();
    frame_outputs_owed <= (tail_open || in_row != 0 || in_col != 0) ?
        width_used() * height_used() - (emit_row * width_used() + emit_col) : 0;
  end
endmodule

// ----- tb/rgb_conv2d_mirror_edges_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_conv2d_mirror_edges_core_tb
// Streams frames of several sizes and mask shapes through the convolution
// core under changing handshake pressure; a checker predicts every output.
// ----------------------------------------------------------------------------
module rgb_conv2d_mirror_edges_core_tb;
  import rcm_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            cmd;
  logic [4:0]            coef_row;
  logic [4:0]            coef_col;
  logic signed [17:0]    coef_value;
  logic [7:0]            pixel_red, pixel_green, pixel_blue;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_red, out_green, out_blue;
  logic [15:0]           out_row;
  logic [9:0]            out_col;
  logic                  frame_last;
  int                    errors, pixels_pending, frame_outputs_owed;
  idle_mode_t            idle_mode;

  rgb_conv2d_mirror_edges_core u_top (.*);

  rgb_conv2d_mirror_edges_core_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (idle_mode == IDLE_RECV)
      out_ready <= ($urandom_range(99) >= 73);
    else if (idle_mode == IDLE_BOTH)
      out_ready <= ($urandom_range(99) >= 15);
    else
      out_ready <= 1'b1;
  end

  // Valid is left high after a beat so the next beat can follow without a gap;
  // anything that waits must lower it first.
  task automatic send_beat(input logic [1:0] c, input logic [4:0] r, input logic [4:0] k,
                           input logic signed [17:0] v, input logic [23:0] px);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 73 : (idle_mode == IDLE_BOTH) ? 15 : 0;
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < gap_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    coef_row <= r;
    coef_col <= k;
    coef_value <= v;
    {pixel_blue, pixel_green, pixel_red} <= px;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup_frame(input int w, input int h, input int mh, input int mw);
    settle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_MASK_HEIGHT, mh);
    write_reg(REG_MASK_WIDTH, mw);
  endtask

  task automatic load_kernel(input int mh, input int mw);
    int rows, cols, base, v;
    rows = (mh > 25) ? 25 : mh;
    cols = (mw > 25) ? 25 : mw;
    base = 65536 / ((rows * cols == 0) ? 1 : rows * cols);
    for (int m = 0; m < rows; m++)
      for (int n = 0; n < cols; n++) begin
        v = $urandom_range(10) == 0 ? -int'($urandom_range(base)) :
            int'($urandom_range((2 * base > 131071) ? 131071 : 2 * base));
        send_beat(CMD_COEF, m[4:0], n[4:0], v[17:0], $urandom);
      end
  endtask

  // Feeds one frame with occasional noise beats, then drains its tail.
  task automatic stream_frame(input int w, input int h);
    int roll;
    for (int i = 0; i < w * h; i++) begin
      roll = $urandom_range(99);
      if (roll < 3)
        send_beat(2'd3, $urandom, $urandom, $urandom, $urandom);
      else if (roll < 6)
        send_beat(CMD_COEF, 5'd25 + 5'($urandom_range(6)), $urandom, $urandom, $urandom);
      else if (roll < 9)
        send_beat(CMD_DRAIN, $urandom, $urandom, $urandom, $urandom);
      send_beat(CMD_PIXEL, $urandom, $urandom, $urandom, $urandom);
    end
    while (frame_outputs_owed != 0)
      send_beat(($urandom_range(3) == 0) ? CMD_PIXEL : CMD_DRAIN,
                $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic run_frame(input int w, input int h, input int mh, input int mw,
                           input idle_mode_t mode);
    int wu, hu;
    setup_frame(w, h, mh, mw);
    idle_mode = mode;
    load_kernel(mh, mw);
    wu = (w < 1) ? 1 : (w > 1024) ? 1024 : w;
    hu = (h == 0) ? 1 : h;
    stream_frame(wu, hu);
  endtask

  initial begin
    int w, h, mh, mw;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    cmd = CMD_DRAIN;
    coef_row = '0;
    coef_col = '0;
    coef_value = '0;
    {pixel_blue, pixel_green, pixel_red} = '0;
    idle_mode = IDLE_NONE;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed frame: kernel at both coefficient extremes, pixels at both
    // channel extremes, ignored writes, an unknown command and an idle drain.
    setup_frame(4, 3, 3, 3);
    send_beat(CMD_DRAIN, '0, '0, '0, '0);
    send_beat(2'd3, 5'h1f, 5'h1f, 18'sh1ffff, 24'hffffff);
    send_beat(CMD_COEF, 5'd31, 5'd0, 18'sh1ffff, '0);
    send_beat(CMD_COEF, 5'd0, 5'd31, 18'sh1ffff, '0);
    send_beat(CMD_COEF, 5'd0, 5'd0, -18'sd131072, '0);
    send_beat(CMD_COEF, 5'd1, 5'd1, 18'sd131071, '0);
    send_beat(CMD_COEF, 5'd2, 5'd2, 18'sd16384, '0);
    for (int i = 0; i < 12; i++)
      send_beat(CMD_PIXEL, '0, '0, '0, (i % 3 == 0) ? 24'h000000 :
                (i % 3 == 1) ? 24'hffffff : 24'($urandom));
    while (frame_outputs_owed != 0) send_beat(CMD_DRAIN, '0, '0, '0, '0);

    // Frames smaller than the mask, register clamps and even masks.
    run_frame(1, 1, 3, 3, IDLE_SEND);
    run_frame(2, 3, 5, 5, IDLE_RECV);
    run_frame(6, 5, 2, 3, IDLE_BOTH);
    run_frame(3, 3, 0, 0, IDLE_NONE);
    run_frame(0, 0, 1, 1, IDLE_SEND);
    setup_frame(1, 65535, 1, 1);
    run_frame(2047, 1, 1, 1, IDLE_RECV);
    run_frame(5, 4, 25, 25, IDLE_BOTH);
    run_frame(3, 2, 31, 31, IDLE_NONE);
    run_frame(1024, 1, 1, 1, IDLE_NONE);

    for (int p = 0; p < 16; p++) begin
      w = $urandom_range(2, 12);
      h = $urandom_range(2, 8);
      mh = 2 * $urandom_range(0, 3) + 1;
      mw = 2 * $urandom_range(0, 3) + 1;
      if ($urandom_range(7) == 0) mw = mw + 1;
      run_frame(w, h, mh, mw, idle_mode_t'(p % 4));
    end

    settle();
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/rcm_pkg.sv
hw/rtl/rgb_conv2d_mirror_edges_core.sv
tb/rgb_conv2d_mirror_edges_core_checker.sv
tb/rgb_conv2d_mirror_edges_core_tb.sv
